// ===== hdl/simon_pkg.sv =====
// ----------------------------------------------------------------------------
// simon_pkg
// Shared types and constants for the SIMON32/64 encryption pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package simon_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned BlockW = 2 * WordW;
  localparam int unsigned KeyW   = 4 * WordW;
  localparam int unsigned ZLen   = 31;

  typedef logic [WordW-1:0]       word_t;
  typedef logic [BlockW-1:0]      block_t;
  typedef logic [KeyW-1:0]        key_t;
  // Sliding window of four round keys; entry 0 is the key used this round.
  typedef logic [3:0][WordW-1:0]  key_win_t;

  typedef struct packed {
    word_t left;
    word_t right;
  } half_pair_t;

  // z0 sequence, element 0 in the leftmost bit (period 31).
  localparam logic [0:ZLen-1] Z0_SEQ = 31'b1111101000100101011000011100110;

  localparam word_t KEY_CONST = 16'hfffc;

endpackage

`default_nettype wire

// ===== hdl/simon_plain_if.sv =====
// ----------------------------------------------------------------------------
// simon_plain_if
// Valid/ready channel carrying one plaintext block per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface simon_plain_if;
  logic                  valid;
  logic                  ready;
  simon_pkg::block_t     plain_block;

  modport source (output valid, output plain_block, input ready);
  modport sink   (input valid, input plain_block, output ready);
endinterface

`default_nettype wire

// ===== hdl/simon_cipher_if.sv =====
// ----------------------------------------------------------------------------
// simon_cipher_if
// Valid/ready channel carrying one ciphertext block per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface simon_cipher_if;
  logic                  valid;
  logic                  ready;
  simon_pkg::block_t     cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink   (input valid, input cipher_block, output ready);
endinterface

`default_nettype wire

// ===== hdl/simon32_64_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// simon32_64_block_encrypt
// SIMON32/64 encryption, fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// Encrypts 32-bit blocks under the 64-bit key in cfg_wdata (low word is the
// first round key; block layout is left word high, right word low). The
// pipeline has ROUNDS register stages, each doing one round and one key
// schedule step, so a block is accepted every cycle while the output is not
// stalled. The round keys travel with each block down the pipeline, so a key
// write takes effect for the very next block. Backpressure on the output holds
// a full stage only when every stage after it is full too; stages upstream of
// an empty stage keep advancing.
`default_nettype none

module simon32_64_block_encrypt #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  simon_pkg::key_t         cfg_wdata,
  simon_plain_if.sink             in_ch,
  simon_cipher_if.source          out_ch
);
  import simon_pkg::*;

  key_t        key_r;
  logic        vld_r   [ROUNDS];
  half_pair_t  state_r [ROUNDS];
  key_win_t    kwin_r  [ROUNDS];
  logic        adv     [ROUNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r <= cfg_wdata;
    end
  end

  assign adv[ROUNDS] = out_ch.ready;
  assign in_ch.ready = adv[0];

  for (genvar s = 0; s < ROUNDS; s++) begin : g_stage
    half_pair_t src_state;
    key_win_t   src_key;
    logic       src_vld;
    half_pair_t nxt_state;
    key_win_t   nxt_key;

    if (s == 0) begin : g_head
      assign src_state = half_pair_t'(in_ch.plain_block);
      assign src_key   = key_win_t'(key_r);
      assign src_vld   = in_ch.valid;
    end else begin : g_body
      assign src_state = state_r[s-1];
      assign src_key   = kwin_r[s-1];
      assign src_vld   = vld_r[s-1];
    end

    simon_round u_round (
      .state_in  (src_state),
      .key_in    (src_key),
      .z_bit     (Z0_SEQ[s % ZLen]),
      .state_out (nxt_state),
      .key_out   (nxt_key)
    );

    // A stage can take new data when empty or when its content moves on.
    assign adv[s] = !vld_r[s] || adv[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv[s]) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s] && src_vld) begin
        state_r[s] <= nxt_state;
        kwin_r[s]  <= nxt_key;
      end
    end
  end

  assign out_ch.valid        = vld_r[ROUNDS-1];
  assign out_ch.cipher_block = block_t'(state_r[ROUNDS-1]);

endmodule

`default_nettype wire

// ===== hdl/simon_round.sv =====
// ----------------------------------------------------------------------------
// simon_round
// One SIMON32/64 round plus one step of the key schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module simon_round (
  input  simon_pkg::half_pair_t  state_in,
  input  simon_pkg::key_win_t    key_in,
  input  logic                   z_bit,
  output simon_pkg::half_pair_t  state_out,
  output simon_pkg::key_win_t    key_out
);
  import simon_pkg::*;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (WordW - s));
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = (v >> s) | (v << (WordW - s));
  endfunction

  word_t l;
  word_t t;
  word_t k_next;

  assign l = state_in.left;

  always_comb begin
    state_out.left  = state_in.right ^ (rotl(l, 1) & rotl(l, 8)) ^ rotl(l, 2) ^ key_in[0];
    state_out.right = l;
  end

  // k[i+4] = k[i] ^ t ^ rotr1(t) ^ z ^ const, t = rotr3(k[i+3]) ^ k[i+1]
  assign t      = rotr(key_in[3], 3) ^ key_in[1];
  assign k_next = key_in[0] ^ t ^ rotr(t, 1) ^ {{(WordW-1){1'b0}}, z_bit} ^ KEY_CONST;

  always_comb begin
    key_out[0] = key_in[1];
    key_out[1] = key_in[2];
    key_out[2] = key_in[3];
    key_out[3] = k_next;
  end

endmodule

`default_nettype wire

// ===== bench/simon_cipher_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simon_cipher_check
// Watches the key port and both block channels of the SIMON32/64 encryption
// pipeline. It computes the expected ciphertext of every accepted plaintext
// under the key in force and compares it with each ciphertext transaction.
// ----------------------------------------------------------------------------
module simon_cipher_check #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  simon_pkg::key_t      cfg_wdata,
  input  logic                 plain_valid,
  input  logic                 plain_ready,
  input  simon_pkg::block_t    plain_block,
  input  logic                 cipher_valid,
  input  logic                 cipher_ready,
  input  simon_pkg::block_t    cipher_block,
  output int unsigned          errors,
  output int unsigned          outstanding
);
  import simon_pkg::*;

  // z0 sequence, element 0 leftmost
  localparam logic [0:30] Z0_BITS     = 31'b1111101000100101011000011100110;
  localparam word_t       ROUND_CONST = 16'hfffc;

  typedef struct {
    block_t plain;
    block_t cipher;
  } cipher_expect_t;

  key_t           key_reg = '0;
  cipher_expect_t cipher_expected[$];

  function automatic word_t rotl16(word_t v, int unsigned s);
    return (v << s) | (v >> (16 - s));
  endfunction

  function automatic word_t rotr16(word_t v, int unsigned s);
    return (v >> s) | (v << (16 - s));
  endfunction

  function automatic block_t simon_encrypt(key_t key, block_t pt);
    word_t rk [ROUNDS + 4];
    word_t t;
    word_t x;
    word_t y;
    word_t nx;
    int    i;
    for (i = 0; i < 4; i++) rk[i] = key[16*i +: 16];
    for (i = 4; i < ROUNDS; i++) begin
      t     = rotr16(rk[i-1], 3) ^ rk[i-3];
      t     = t ^ rotr16(t, 1);
      rk[i] = rk[i-4] ^ t ^ word_t'(Z0_BITS[(i-4) % 31]) ^ ROUND_CONST;
    end
    x = pt[31:16];
    y = pt[15:0];
    for (i = 0; i < ROUNDS; i++) begin
      nx = y ^ (rotl16(x, 1) & rotl16(x, 8)) ^ rotl16(x, 2) ^ rk[i];
      y  = x;
      x  = nx;
    end
    return {x, y};
  endfunction

  always @(posedge clk) begin
    cipher_expect_t exp_item;
    if (!rst_n) begin
      key_reg <= '0;
      cipher_expected.delete();
      errors      <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) key_reg <= cfg_wdata;
      if (cipher_valid && cipher_ready) begin
        if (cipher_expected.size() == 0) begin
          $display("%0t: unexpected cipher block %h", $time, cipher_block);
          errors <= errors + 1;
        end else begin
          exp_item = cipher_expected.pop_front();
          if (cipher_block !== exp_item.cipher) begin
            $display("%0t: cipher_block mismatch for plain %h: expected %h, actual %h",
                     $time, exp_item.plain, exp_item.cipher, cipher_block);
            errors <= errors + 1;
          end
        end
      end
      // key_reg still holds the key in force before this edge
      if (plain_valid && plain_ready)
        cipher_expected.push_back('{plain: plain_block,
                                    cipher: simon_encrypt(key_reg, plain_block)});
      outstanding <= cipher_expected.size();
    end
  end

endmodule

// ===== bench/tb_simon32_64_block_encrypt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simon32_64_block_encrypt
// Drives plaintext blocks into the SIMON32/64 pipeline under a series of keys,
// with bursty input and an irregular output stall pattern, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb_simon32_64_block_encrypt;
  import simon_pkg::*;

  localparam int unsigned ROUNDS       = 32;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 52;
  localparam int unsigned NUM_PHASES   = 8;
  localparam key_t        KEY_VECTOR   = 64'h1918_1110_0908_0100;
  localparam block_t      CORNER_BLOCKS [12] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_ffff, 32'hffff_0000,
    32'h6565_6877, 32'h8000_0000, 32'h0000_0001, 32'h5555_5555,
    32'haaaa_aaaa, 32'h0000_8000, 32'h8000_8000, 32'h7fff_7fff
  };

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   cfg_we    = 1'b0;
  key_t   cfg_wdata = '0;
  logic   in_valid  = 1'b0;
  block_t in_block  = '0;
  logic   rx_ready  = 1'b0;
  logic   hold_req  = 1'b0;

  rx_mode_e    rx_mode      = RX_FREE;
  int unsigned mode_left    = 0;
  int unsigned hold_left    = 0;
  int unsigned stuck_cycles = 0;
  int unsigned burst_left   = 0;
  bit          steady       = 1'b0;
  int unsigned errors;
  int unsigned outstanding;

  simon_plain_if  plain_ch();
  simon_cipher_if cipher_ch();

  assign plain_ch.valid       = in_valid;
  assign plain_ch.plain_block = in_block;
  assign cipher_ch.ready      = rx_ready;

  always #6 clk = ~clk;

  simon32_64_block_encrypt #(.ROUNDS(ROUNDS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (plain_ch),
    .out_ch    (cipher_ch)
  );

  simon_cipher_check #(.ROUNDS(ROUNDS)) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .plain_valid  (in_valid),
    .plain_ready  (plain_ch.ready),
    .plain_block  (in_block),
    .cipher_valid (cipher_ch.valid),
    .cipher_ready (rx_ready),
    .cipher_block (cipher_ch.cipher_block),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  // Receiver: random stall modes, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      rx_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_ready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FREE:     rx_ready <= 1'b1;
        RX_COIN:     rx_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   rx_ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: rx_ready <= (mode_left % 7 < 3);
        default:     rx_ready <= 1'b1;
      endcase
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && plain_ch.ready) || (cipher_ch.valid && rx_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("simon32_64_block_encrypt test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one block; returns at the edge where it was accepted.
  task automatic send_block(block_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_block <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_block <= b;
    @(posedge clk);
    while (!plain_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Key writes only with the pipeline empty.
  task automatic write_key(key_t k);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    key_t   k;
    block_t b;
    int     ph;
    int     i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // corner blocks under the reset key, then under the published test key
    foreach (CORNER_BLOCKS[j]) send_block(CORNER_BLOCKS[j]);
    write_key(KEY_VECTOR);
    foreach (CORNER_BLOCKS[j]) send_block(CORNER_BLOCKS[j]);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       k = '1;
        1:       k = '0;
        2:       k = 64'h8000_0000_0000_0001;
        default: k = {$urandom, $urandom};
      endcase
      write_key(k);
      steady = (ph == 6);
      if (ph == 3) begin
        // long output hold-off while input keeps coming: pipeline fills
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2) wait_drained();
        case ($urandom_range(0, 5))
          0:       b = 32'h1 << $urandom_range(0, 31);
          1:       b = ~(32'h1 << $urandom_range(0, 31));
          2:       b = {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
          default: b = $urandom;
        endcase
        send_block(b);
      end
    end

    wait_drained();
    repeat (ROUNDS + 16) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("simon32_64_block_encrypt test passed");
    end else begin
      $display("simon32_64_block_encrypt test failed");
    end
    $finish;
  end

endmodule
